@@ rtl/fpbr_pkg.sv @@
// Shared types and constants for the floating-point branch resolver.
// Holds the transaction payload structs, the decode result struct and the encodings.
// No dependencies.
package fpbr_pkg;

    // Width of the word displacement after the shift by two, sign included.
    localparam int unsigned DISP_W = 24;

    // The op2 code of the V9 predicted floating-point branch.
    localparam logic [2:0] OP2_FBPFCC = 3'd5;

    // The instruction class that holds the branches (bits 31:30).
    localparam logic [1:0] OP_BRANCH = 2'd0;

    // Floating-point condition code values.
    typedef enum logic [1:0] {
        FCC_E = 2'd0,
        FCC_L = 2'd1,
        FCC_G = 2'd2,
        FCC_U = 2'd3
    } t_fcc;

    // Branch conditions, instruction bits 28:25.
    typedef enum logic [3:0] {
        FB_N   = 4'd0,
        FB_NE  = 4'd1,
        FB_LG  = 4'd2,
        FB_UL  = 4'd3,
        FB_L   = 4'd4,
        FB_UG  = 4'd5,
        FB_G   = 4'd6,
        FB_U   = 4'd7,
        FB_A   = 4'd8,
        FB_E   = 4'd9,
        FB_UE  = 4'd10,
        FB_GE  = 4'd11,
        FB_UGE = 4'd12,
        FB_LE  = 4'd13,
        FB_ULE = 4'd14,
        FB_O   = 4'd15
    } t_fb_cond;

    // Input transaction.
    typedef struct packed {
        logic [31:0] instruction;
        logic [1:0]  fcc0;
        logic [1:0]  fcc1;
        logic [1:0]  fcc2;
        logic [1:0]  fcc3;
        logic [63:0] pc;
        logic [63:0] npc;
    } t_fpbr_in;

    // Output transaction.
    typedef struct packed {
        logic [63:0] new_pc;
        logic [63:0] new_npc;
        logic        taken;
        logic        status;
    } t_fpbr_out;

    // Decoded branch, passed from the decoder into the pipeline.
    typedef struct packed {
        logic                     handled;
        logic                     annul;
        logic                     always_annul;
        logic                     taken;
        logic signed [DISP_W-1:0] disp;
    } t_fpbr_dec;

endpackage

@@ rtl/fpbr_decode.sv @@
// Decoder of the floating-point branch resolver: class check, fcc selection,
// condition evaluation and displacement extraction. Depends on fpbr_pkg.
module fpbr_decode import fpbr_pkg::*; (
    input  t_fpbr_in  i_in,
    input  logic      i_v9_mode,
    output t_fpbr_dec o_dec
);

    logic        w_pred;
    logic [1:0]  w_fcc;
    logic        w_e;
    logic        w_l;
    logic        w_g;
    logic        w_u;
    logic        w_take;
    t_fb_cond    w_cond;

    assign w_cond = t_fb_cond'(i_in.instruction[28:25]);
    assign w_pred = i_v9_mode && (i_in.instruction[24:22] == OP2_FBPFCC);

    // The predicted form picks one of four condition codes; all others use fcc0.
    always_comb begin
        w_fcc = i_in.fcc0;
        if (w_pred) begin
            unique case (i_in.instruction[21:20])
                2'd0:    w_fcc = i_in.fcc0;
                2'd1:    w_fcc = i_in.fcc1;
                2'd2:    w_fcc = i_in.fcc2;
                default: w_fcc = i_in.fcc3;
            endcase
        end
    end

    assign w_e = (w_fcc == FCC_E);
    assign w_l = (w_fcc == FCC_L);
    assign w_g = (w_fcc == FCC_G);
    assign w_u = (w_fcc == FCC_U);

    // Condition table.
    always_comb begin
        unique case (w_cond)
            FB_N:   w_take = 1'b0;
            FB_NE:  w_take = !w_e;
            FB_LG:  w_take = w_l || w_g;
            FB_UL:  w_take = w_u || w_l;
            FB_L:   w_take = w_l;
            FB_UG:  w_take = w_u || w_g;
            FB_G:   w_take = w_g;
            FB_U:   w_take = w_u;
            FB_A:   w_take = 1'b1;
            FB_E:   w_take = w_e;
            FB_UE:  w_take = w_u || w_e;
            FB_GE:  w_take = w_g || w_e;
            FB_UGE: w_take = !w_l;
            FB_LE:  w_take = w_l || w_e;
            FB_ULE: w_take = !w_g;
            FB_O:   w_take = !w_u;
            default: w_take = 1'b0;
        endcase
    end

    // Assemble the decode result with the byte displacement already sign-extended.
    always_comb begin
        o_dec.handled      = (i_in.instruction[31:30] == OP_BRANCH);
        o_dec.annul        = i_in.instruction[29];
        o_dec.always_annul = i_in.instruction[29] && (w_cond == FB_A);
        o_dec.taken        = w_take;
        if (w_pred) begin
            o_dec.disp = DISP_W'($signed({i_in.instruction[18:0], 2'b00}));
        end else begin
            o_dec.disp = DISP_W'($signed({i_in.instruction[21:0], 2'b00}));
        end
    end

endmodule

@@ rtl/fp_branch_condition_next_pc.sv @@
// Top level of the floating-point branch resolver: three-stage pipeline.
// Depends on fpbr_pkg and fpbr_decode.
//
// Resolves one SPARC floating-point branch (FBfcc, and FBPfcc when V9 mode is set)
// per transaction into the next pc and npc, a taken flag and a status bit that is
// set for instructions outside the branch class, which pass pc and npc through.
// The block takes one transaction every cycle unless o_in_stall is raised, and each result
// passes through decode and condition evaluation, then the target and
// sequential address adders, then target+4 and the result selection into the
// output register. Computed addresses wrap at ADDR_WIDTH bits and are zero-extended
// to 64. While the output is stalled, the earlier stages keep accepting until all
// three hold a transaction. The V9 mode register resets to 1.
module fp_branch_condition_next_pc import fpbr_pkg::*; #(
    parameter int unsigned ADDR_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_fpbr_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_fpbr_out o_out_data
);

    localparam int unsigned AW = ADDR_WIDTH;

    logic          r_v9_mode;
    t_fpbr_dec     w_dec;

    logic          w_en1;
    logic          w_en2;
    logic          w_en3;

    logic          r_s1_valid;
    t_fpbr_dec     r_s1_dec;
    logic [63:0]   r_s1_pc;
    logic [63:0]   r_s1_npc;

    logic          r_s2_valid;
    logic          r_s2_handled;
    logic          r_s2_always_annul;
    logic          r_s2_annul;
    logic          r_s2_taken;
    logic [63:0]   r_s2_pc;
    logic [63:0]   r_s2_npc;
    logic [AW-1:0] r_s2_target;
    logic [AW-1:0] r_s2_npc4;
    logic [AW-1:0] r_s2_npc8;

    logic          r_out_valid;
    t_fpbr_out     r_out;

    logic [AW-1:0] n_s2_target;
    logic [AW-1:0] n_s2_npc4;
    logic [AW-1:0] n_s2_npc8;
    logic [AW-1:0] w_target4;
    logic [AW-1:0] w_sel_pc;
    logic [AW-1:0] w_sel_npc;
    t_fpbr_out     n_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_v9_mode <= i_cfg_wdata;
        end
    end

    // Stage enables: a stage loads when it is empty or the one after it moves.
    assign w_en3      = !r_out_valid || !i_out_stall;
    assign w_en2      = !r_s2_valid || w_en3;
    assign w_en1      = !r_s1_valid || w_en2;
    assign o_in_stall = !w_en1;

    // Stage 1: decode and condition evaluation.
    fpbr_decode u_decode (
        .i_in      (i_in_data),
        .i_v9_mode (r_v9_mode),
        .o_dec     (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_s1_dec <= w_dec;
            r_s1_pc  <= i_in_data.pc;
            r_s1_npc <= i_in_data.npc;
        end
    end

    // Stage 2: branch target and sequential addresses, all wrapped to AW bits.
    assign n_s2_target = r_s1_pc[AW-1:0] + AW'($signed(r_s1_dec.disp));
    assign n_s2_npc4   = r_s1_npc[AW-1:0] + AW'(4);
    assign n_s2_npc8   = r_s1_npc[AW-1:0] + AW'(8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_valid) begin
            r_s2_handled      <= r_s1_dec.handled;
            r_s2_always_annul <= r_s1_dec.always_annul;
            r_s2_annul        <= r_s1_dec.annul;
            r_s2_taken        <= r_s1_dec.taken;
            r_s2_pc           <= r_s1_pc;
            r_s2_npc          <= r_s1_npc;
            r_s2_target       <= n_s2_target;
            r_s2_npc4         <= n_s2_npc4;
            r_s2_npc8         <= n_s2_npc8;
        end
    end

    // Stage 3: pick the next pc and npc for the four branch outcomes.
    assign w_target4 = r_s2_target + AW'(4);

    always_comb begin
        if (r_s2_taken && r_s2_always_annul) begin
            w_sel_pc  = r_s2_target;
            w_sel_npc = w_target4;
        end else if (r_s2_taken) begin
            w_sel_pc  = r_s2_npc[AW-1:0];
            w_sel_npc = r_s2_target;
        end else if (r_s2_annul) begin
            w_sel_pc  = r_s2_npc4;
            w_sel_npc = r_s2_npc8;
        end else begin
            w_sel_pc  = r_s2_npc[AW-1:0];
            w_sel_npc = r_s2_npc4;
        end
    end

    // Non-branch instructions pass pc and npc through untouched.
    always_comb begin
        n_out = '0;
        if (r_s2_handled) begin
            n_out.new_pc[AW-1:0]  = w_sel_pc;
            n_out.new_npc[AW-1:0] = w_sel_npc;
            n_out.taken           = r_s2_taken;
            n_out.status          = 1'b0;
        end else begin
            n_out.new_pc  = r_s2_pc;
            n_out.new_npc = r_s2_npc;
            n_out.taken   = 1'b0;
            n_out.status  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted transaction always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("accepted transaction did not enter stage 1");

    // The input stalls only when every stage holds a transaction.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");

    // A transaction in stage 2 moves to the output when the output is free.
    a_stage2_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !(r_out_valid && i_out_stall)) |=> r_out_valid)
        else $error("stage 2 transaction was lost");

    // A not-handled result never reports a taken branch.
    a_status_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> !r_out.taken)
        else $error("not-handled result flagged as taken");

endmodule
